// ----- rtl/core/ppect_pkg.sv -----
// ----------------------------------------------------------------------------
// ppect_pkg
// Shared types and constants of the per-process event count table.
// ----------------------------------------------------------------------------
package ppect_pkg;

    localparam int SLOT_COUNT_DEF  = 512;
    localparam int EVENT_COUNT_DEF = 512;

    localparam int PID_W   = 22;
    localparam int EVID_W  = 9;
    localparam int SLOTI_W = 9;
    localparam int CNT_W   = 32;
    localparam int STAT_W  = 3;

    typedef enum logic [STAT_W-1:0] {
        ST_EXISTING = 3'd0,
        ST_CLAIMED  = 3'd1,
        ST_DROPPED  = 3'd2,
        ST_FOUND    = 3'd3,
        ST_NONE     = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        RES_HOLD,
        RES_DROP,
        RES_CLAIM,
        RES_EXIST,
        RES_FOUND,
        RES_EMPTY
    } t_res_kind;

    typedef enum logic [3:0] {
        S_IDLE,
        S_C_CHK,
        S_C_SRCH,
        S_C_CMP,
        S_C_INC,
        S_C_CLR,
        S_S_CHK,
        S_S_OWN,
        S_S_OWNCHK,
        S_S_CNT,
        S_S_CNTCHK,
        S_DONE
    } t_state;

    typedef struct packed {
        logic      load;
        logic      slot_inc;
        logic      evi_clr;
        logic      evi_inc;
        logic      own_rd;
        logic      cnt_rd;
        logic      cnt_wr_sat;
        logic      clr_wr;
        logic      claim;
        t_res_kind res;
        logic      push;
    } t_cmd;

    typedef struct packed {
        logic mode;
        logic ev_bad;
        logic start_bad;
        logic slot_end;
        logic full;
        logic own_match;
        logic own_zero;
        logic cnt_zero;
        logic evi_last;
        logic out_free;
    } t_sts;

endpackage

// ----- rtl/core/ppect_if.sv -----
// ----------------------------------------------------------------------------
// ppect_in_if / ppect_out_if
// Valid/ready channels carrying request items and result items.
// ----------------------------------------------------------------------------
interface ppect_in_if;
    logic        valid;
    logic        ready;
    logic        mode;
    logic [21:0] process_id;
    logic [8:0]  event_id;
    logic [8:0]  start_slot;

    modport source (output valid, mode, process_id, event_id, start_slot, input ready);
    modport sink   (input valid, mode, process_id, event_id, start_slot, output ready);
endinterface

interface ppect_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [8:0]  slot_index;
    logic [8:0]  event_index;
    logic [21:0] owner_id;
    logic [31:0] event_count;

    modport source (output valid, status, slot_index, event_index, owner_id, event_count,
                    input ready);
    modport sink   (input valid, status, slot_index, event_index, owner_id, event_count,
                    output ready);
endinterface

// ----- rtl/core/ppect_ctrl.sv -----
// ----------------------------------------------------------------------------
// ppect_ctrl
// Sequencer for slot search, row clear on claim, counter update and scan.
// ----------------------------------------------------------------------------
module ppect_ctrl
    import ppect_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_cmd.res  = RES_HOLD;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = i_sts.mode ? S_S_CHK : S_C_CHK;
                end
            end
            S_C_CHK: begin
                if (i_sts.ev_bad) begin
                    o_cmd.res = RES_DROP;
                    n_state   = S_DONE;
                end else begin
                    n_state = S_C_SRCH;
                end
            end
            S_C_SRCH: begin
                if (i_sts.slot_end) begin
                    if (i_sts.full) begin
                        o_cmd.res = RES_DROP;
                        n_state   = S_DONE;
                    end else begin
                        o_cmd.evi_clr = 1'b1;
                        n_state       = S_C_CLR;
                    end
                end else begin
                    o_cmd.own_rd = 1'b1;
                    n_state      = S_C_CMP;
                end
            end
            S_C_CMP: begin
                if (i_sts.own_match) begin
                    o_cmd.cnt_rd = 1'b1;
                    n_state      = S_C_INC;
                end else begin
                    o_cmd.slot_inc = 1'b1;
                    n_state        = S_C_SRCH;
                end
            end
            S_C_INC: begin
                o_cmd.cnt_wr_sat = 1'b1;
                o_cmd.res        = RES_EXIST;
                n_state          = S_DONE;
            end
            S_C_CLR: begin
                // sweep the new row, the counted event gets one
                o_cmd.clr_wr = 1'b1;
                if (i_sts.evi_last) begin
                    o_cmd.claim = 1'b1;
                    o_cmd.res   = RES_CLAIM;
                    n_state     = S_DONE;
                end else begin
                    o_cmd.evi_inc = 1'b1;
                end
            end
            S_S_CHK: begin
                if (i_sts.start_bad) begin
                    o_cmd.res = RES_EMPTY;
                    n_state   = S_DONE;
                end else begin
                    n_state = S_S_OWN;
                end
            end
            S_S_OWN: begin
                if (i_sts.slot_end) begin
                    o_cmd.res = RES_EMPTY;
                    n_state   = S_DONE;
                end else begin
                    o_cmd.own_rd = 1'b1;
                    n_state      = S_S_OWNCHK;
                end
            end
            S_S_OWNCHK: begin
                if (i_sts.own_zero) begin
                    o_cmd.slot_inc = 1'b1;
                    o_cmd.evi_clr  = 1'b1;
                    n_state        = S_S_OWN;
                end else begin
                    n_state = S_S_CNT;
                end
            end
            S_S_CNT: begin
                o_cmd.cnt_rd = 1'b1;
                n_state      = S_S_CNTCHK;
            end
            S_S_CNTCHK: begin
                if (!i_sts.cnt_zero) begin
                    o_cmd.res = RES_FOUND;
                    n_state   = S_DONE;
                end else if (i_sts.evi_last) begin
                    o_cmd.slot_inc = 1'b1;
                    o_cmd.evi_clr  = 1'b1;
                    n_state        = S_S_OWN;
                end else begin
                    o_cmd.evi_inc = 1'b1;
                    n_state       = S_S_CNT;
                end
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.push = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/core/ppect_dp.sv -----
// ----------------------------------------------------------------------------
// ppect_dp
// Owner and counter memories, iteration counters and result registers.
// ----------------------------------------------------------------------------
module ppect_dp
    import ppect_pkg::*;
#(
    parameter int SLOT_COUNT  = SLOT_COUNT_DEF,
    parameter int EVENT_COUNT = EVENT_COUNT_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_mode,
    input  logic [PID_W-1:0]   i_process_id,
    input  logic [EVID_W-1:0]  i_event_id,
    input  logic [SLOTI_W-1:0] i_start_slot,
    input  t_cmd               i_cmd,
    output t_sts               o_sts,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    output logic [STAT_W-1:0]  o_status,
    output logic [SLOTI_W-1:0] o_slot_index,
    output logic [EVID_W-1:0]  o_event_index,
    output logic [PID_W-1:0]   o_owner_id,
    output logic [CNT_W-1:0]   o_event_count
);

    localparam int SW   = $clog2(SLOT_COUNT);
    localparam int EW   = $clog2(EVENT_COUNT);
    localparam int LW   = (SW + 1 > 10) ? SW + 1 : 10;
    localparam int XW   = (EW + 1 > 10) ? EW + 1 : 10;
    localparam int CAW  = SW + EW;
    localparam int CDEP = 1 << CAW;

    logic [PID_W-1:0] owner_mem [SLOT_COUNT];
    logic [CNT_W-1:0] cnt_mem   [CDEP];

    logic [PID_W-1:0]  r_pid;
    logic [EVID_W-1:0] r_ev;
    logic              r_ev_bad;
    logic              r_start_bad;
    logic [SW:0]       r_fill;
    logic [SW:0]       r_slot;
    logic [EW:0]       r_evi;
    logic [PID_W-1:0]  r_own_q;
    logic [CNT_W-1:0]  r_cnt_q;

    t_status            r_res_status;
    logic [SLOTI_W-1:0] r_res_slot;
    logic [EVID_W-1:0]  r_res_ev;
    logic [PID_W-1:0]   r_res_owner;
    logic [CNT_W-1:0]   r_res_count;

    logic               r_ovalid;
    logic [STAT_W-1:0]  r_o_status;
    logic [SLOTI_W-1:0] r_o_slot;
    logic [EVID_W-1:0]  r_o_ev;
    logic [PID_W-1:0]   r_o_owner;
    logic [CNT_W-1:0]   r_o_count;

    logic [XW-1:0]    in_ev_w;
    logic             in_ev_bad;
    logic [LW-1:0]    in_start_w;
    logic [LW-1:0]    slot_w;
    logic [XW-1:0]    evi_w;
    logic [CAW-1:0]   cnt_addr;
    logic [CNT_W-1:0] cnt_sat;
    logic             evi_hit;

    assign in_ev_w    = XW'(i_event_id);
    assign in_ev_bad  = in_ev_w >= XW'(EVENT_COUNT);
    // a start event past the row moves the scan to the next slot
    assign in_start_w = LW'(i_start_slot) + LW'(in_ev_bad);
    assign slot_w     = LW'(r_slot);
    assign evi_w      = XW'(r_evi);
    assign cnt_addr   = {r_slot[SW-1:0], r_evi[EW-1:0]};
    assign cnt_sat    = (r_cnt_q == '1) ? r_cnt_q : r_cnt_q + CNT_W'(1);
    assign evi_hit    = evi_w == XW'(r_ev);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cmd.claim) begin
                r_fill <= r_fill + (SW + 1)'(1);
            end
            if (i_cmd.push) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_pid       <= i_process_id;
            r_ev        <= i_event_id;
            r_ev_bad    <= in_ev_bad;
            r_start_bad <= in_start_w >= LW'(r_fill);
            r_slot      <= i_mode ? (SW + 1)'(in_start_w) : '0;
            r_evi       <= (i_mode && in_ev_bad) ? '0 : (EW + 1)'(in_ev_w);
        end else begin
            if (i_cmd.slot_inc) begin
                r_slot <= r_slot + (SW + 1)'(1);
            end
            if (i_cmd.evi_clr) begin
                r_evi <= '0;
            end else if (i_cmd.evi_inc) begin
                r_evi <= r_evi + (EW + 1)'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.claim) begin
            owner_mem[r_slot[SW-1:0]] <= r_pid;
        end
        if (i_cmd.own_rd) begin
            r_own_q <= owner_mem[r_slot[SW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cnt_wr_sat) begin
            cnt_mem[cnt_addr] <= cnt_sat;
        end else if (i_cmd.clr_wr) begin
            cnt_mem[cnt_addr] <= evi_hit ? CNT_W'(1) : '0;
        end
        if (i_cmd.cnt_rd) begin
            r_cnt_q <= cnt_mem[cnt_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.res)
            RES_DROP: begin
                r_res_status <= ST_DROPPED;
                r_res_slot   <= '0;
                r_res_ev     <= r_ev;
                r_res_owner  <= r_pid;
                r_res_count  <= '0;
            end
            RES_CLAIM: begin
                r_res_status <= ST_CLAIMED;
                r_res_slot   <= slot_w[SLOTI_W-1:0];
                r_res_ev     <= r_ev;
                r_res_owner  <= r_pid;
                r_res_count  <= CNT_W'(1);
            end
            RES_EXIST: begin
                r_res_status <= ST_EXISTING;
                r_res_slot   <= slot_w[SLOTI_W-1:0];
                r_res_ev     <= r_ev;
                r_res_owner  <= r_pid;
                r_res_count  <= cnt_sat;
            end
            RES_FOUND: begin
                r_res_status <= ST_FOUND;
                r_res_slot   <= slot_w[SLOTI_W-1:0];
                r_res_ev     <= evi_w[EVID_W-1:0];
                r_res_owner  <= r_own_q;
                r_res_count  <= r_cnt_q;
            end
            RES_EMPTY: begin
                r_res_status <= ST_NONE;
                r_res_slot   <= '0;
                r_res_ev     <= '0;
                r_res_owner  <= '0;
                r_res_count  <= '0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_o_status <= r_res_status;
            r_o_slot   <= r_res_slot;
            r_o_ev     <= r_res_ev;
            r_o_owner  <= r_res_owner;
            r_o_count  <= r_res_count;
        end
    end

    always_comb begin
        o_sts           = '0;
        o_sts.mode      = i_mode;
        o_sts.ev_bad    = r_ev_bad;
        o_sts.start_bad = r_start_bad;
        o_sts.slot_end  = r_slot >= r_fill;
        o_sts.full      = r_fill == (SW + 1)'(SLOT_COUNT);
        o_sts.own_match = r_own_q == r_pid;
        o_sts.own_zero  = r_own_q == '0;
        o_sts.cnt_zero  = r_cnt_q == '0;
        o_sts.evi_last  = r_evi == (EW + 1)'(EVENT_COUNT - 1);
        o_sts.out_free  = !r_ovalid || i_out_ready;
    end

    assign o_out_valid   = r_ovalid;
    assign o_status      = r_o_status;
    assign o_slot_index  = r_o_slot;
    assign o_event_index = r_o_ev;
    assign o_owner_id    = r_o_owner;
    assign o_event_count = r_o_count;

endmodule

// ----- rtl/core/per_process_event_count_table.sv -----
// ----------------------------------------------------------------------------
// per_process_event_count_table
// Per-process event counters with slot claim on first event and a scan for
// the next non-zero counter.
//
//   channel    dir  handshake      payload
//   i_item     in   valid/ready    mode, process_id, event_id, start_slot
//   o_result   out  valid/ready    status, slot_index, event_index,
//                                  owner_id, event_count
//
// one item at a time; the owner search walks the used slots in order through
// the owner memory
// a claim adds a clear of the whole row through the counter memory
// a scan reads each used slot's owner, and the counters of non-zero owners
// reset clears the slot fill count, the output valid and the sequencer state;
// rows are cleared on claim; i_item is taken again while a result still waits on o_result
// ----------------------------------------------------------------------------
module per_process_event_count_table
    import ppect_pkg::*;
#(
    parameter int SLOT_COUNT  = SLOT_COUNT_DEF,
    parameter int EVENT_COUNT = EVENT_COUNT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ppect_in_if.sink    i_item,
    ppect_out_if.source o_result
);

    t_cmd cmd;
    t_sts sts;

    ppect_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_item.valid),
        .o_in_ready (i_item.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    ppect_dp #(
        .SLOT_COUNT  (SLOT_COUNT),
        .EVENT_COUNT (EVENT_COUNT)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_mode        (i_item.mode),
        .i_process_id  (i_item.process_id),
        .i_event_id    (i_item.event_id),
        .i_start_slot  (i_item.start_slot),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_out_ready   (o_result.ready),
        .o_out_valid   (o_result.valid),
        .o_status      (o_result.status),
        .o_slot_index  (o_result.slot_index),
        .o_event_index (o_result.event_index),
        .o_owner_id    (o_result.owner_id),
        .o_event_count (o_result.event_count)
    );

endmodule

// ----- tb/per_process_event_count_table_chk.sv -----
// ----------------------------------------------------------------------------
// per_process_event_count_table_chk
// Watches both channels, keeps a behavioral copy of the slot table and the
// counters, predicts each result item and compares it field by field.
// ----------------------------------------------------------------------------
module per_process_event_count_table_chk
    import ppect_pkg::*;
#(
    parameter int SLOT_COUNT  = SLOT_COUNT_DEF,
    parameter int EVENT_COUNT = EVENT_COUNT_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    ppect_in_if  i_item,
    ppect_out_if i_result,
    output int   o_fail_count,
    output int   o_pending
);

    typedef struct packed {
        t_status              status;
        logic [SLOTI_W-1:0]   slot_index;
        logic [EVID_W-1:0]    event_index;
        logic [PID_W-1:0]     owner_id;
        logic [CNT_W-1:0]     event_count;
    } t_result;

    logic [PID_W-1:0] owner_tbl [SLOT_COUNT];
    bit               used_tbl  [SLOT_COUNT];
    logic [CNT_W-1:0] counter_mem [int];
    t_result          result_q [$];
    int               fail_cnt;

    assign o_fail_count = fail_cnt;
    assign o_pending    = result_q.size();

    function automatic logic [CNT_W-1:0] counter_at(int idx);
        return counter_mem.exists(idx) ? counter_mem[idx] : '0;
    endfunction

    function automatic t_result count_event(logic [PID_W-1:0] pid, logic [EVID_W-1:0] ev);
        t_result r;
        int      hit;
        int      idx;
        logic [CNT_W-1:0] c;
        r = '{ST_DROPPED, '0, ev, pid, '0};
        if (int'(ev) >= EVENT_COUNT) return r;
        hit = -1;
        for (int s = 0; s < SLOT_COUNT; s++) begin
            if (used_tbl[s] && owner_tbl[s] == pid) begin
                hit = s;
                break;
            end
        end
        if (hit >= 0) begin
            idx = hit * EVENT_COUNT + int'(ev);
            c = counter_at(idx);
            if (c != '1) c = c + 1;
            counter_mem[idx] = c;
            return '{ST_EXISTING, SLOTI_W'(hit), ev, pid, c};
        end
        for (int s = 0; s < SLOT_COUNT; s++) begin
            if (!used_tbl[s]) begin
                hit = s;
                break;
            end
        end
        if (hit < 0) return r;
        used_tbl[hit]  = 1'b1;
        owner_tbl[hit] = pid;
        counter_mem[hit * EVENT_COUNT + int'(ev)] = 1;
        return '{ST_CLAIMED, SLOTI_W'(hit), ev, pid, CNT_W'(1)};
    endfunction

    function automatic t_result scan_next(logic [SLOTI_W-1:0] slot, logic [EVID_W-1:0] ev);
        int s0;
        int e0;
        logic [CNT_W-1:0] c;
        s0 = int'(slot);
        e0 = int'(ev);
        if (e0 >= EVENT_COUNT) begin
            s0++;
            e0 = 0;
        end
        for (int s = s0; s < SLOT_COUNT; s++) begin
            if (used_tbl[s] && owner_tbl[s] != '0) begin
                for (int e = (s == s0) ? e0 : 0; e < EVENT_COUNT; e++) begin
                    c = counter_at(s * EVENT_COUNT + e);
                    if (c != '0) return '{ST_FOUND, SLOTI_W'(s), EVID_W'(e), owner_tbl[s], c};
                end
            end
        end
        return '{ST_NONE, '0, '0, '0, '0};
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
        fail_cnt++;
    endtask

    initial begin
        fail_cnt = 0;
        for (int s = 0; s < SLOT_COUNT; s++) begin
            owner_tbl[s] = '0;
            used_tbl[s]  = 1'b0;
        end
    end

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n) begin
            if (i_result.valid && i_result.ready) begin
                if (result_q.size() == 0) begin
                    report_mismatch("unexpected item status", i_result.status, 0);
                end else begin
                    want = result_q.pop_front();
                    if (i_result.status != want.status)
                        report_mismatch("status", i_result.status, want.status);
                    if (i_result.slot_index != want.slot_index)
                        report_mismatch("slot_index", i_result.slot_index, want.slot_index);
                    if (i_result.event_index != want.event_index)
                        report_mismatch("event_index", i_result.event_index, want.event_index);
                    if (i_result.owner_id != want.owner_id)
                        report_mismatch("owner_id", i_result.owner_id, want.owner_id);
                    if (i_result.event_count != want.event_count)
                        report_mismatch("event_count", i_result.event_count, want.event_count);
                end
            end
            if (i_item.valid && i_item.ready) begin
                if (i_item.mode == 1'b0)
                    result_q.push_back(count_event(i_item.process_id, i_item.event_id));
                else
                    result_q.push_back(scan_next(i_item.start_slot, i_item.event_id));
            end
        end
    end

endmodule

// ----- tb/per_process_event_count_table_tb.sv -----
// ----------------------------------------------------------------------------
// per_process_event_count_table_tb
// Drives count and scan requests with random idling on both channels,
// including a long output stall and a drain pause, then fills the table to
// the brim to reach the dropped case. Prediction lives in the checker.
// ----------------------------------------------------------------------------
module per_process_event_count_table_tb
    import ppect_pkg::*;
();

    localparam int WATCHDOG_LIMIT = 200000;
    localparam int RANDOM_ITEMS   = 760;
    localparam int LONG_HOLD      = 3000;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    int   src_idle_pct;
    int   snk_idle_pct;
    bit   hold_req;
    int   quiet_cycles;
    logic [PID_W-1:0] pid_pool [8];

    ppect_in_if  item_ch ();
    ppect_out_if result_ch ();

    per_process_event_count_table dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_ch.sink),
        .o_result (result_ch.source)
    );

    per_process_event_count_table_chk chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (item_ch),
        .i_result     (result_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // receiver side: random stalls plus one long hold-off on request
    initial begin
        result_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                result_ch.ready = 1'b0;
                repeat (LONG_HOLD) @(negedge i_clk);
                hold_req = 1'b0;
            end
            result_ch.ready = ($urandom_range(99) >= snk_idle_pct);
        end
    end

    // watchdog on cycles without any accepted item
    initial begin
        quiet_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    task automatic send_item(logic mode, logic [PID_W-1:0] pid, logic [EVID_W-1:0] ev,
                             logic [SLOTI_W-1:0] slot);
        while ($urandom_range(99) < src_idle_pct) begin
            item_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        item_ch.valid      = 1'b1;
        item_ch.mode       = mode;
        item_ch.process_id = pid;
        item_ch.event_id   = ev;
        item_ch.start_slot = slot;
        do @(posedge i_clk); while (!item_ch.ready);
        @(negedge i_clk);
        item_ch.valid = 1'b0;
    endtask

    task automatic drain();
        while (pending != 0) @(negedge i_clk);
    endtask

    function automatic logic [EVID_W-1:0] pick_event();
        return ($urandom_range(99) < 80) ? EVID_W'($urandom_range(15)) : EVID_W'($urandom);
    endfunction

    initial begin
        logic [PID_W-1:0] pid;
        i_rst_n            = 1'b0;
        item_ch.valid      = 1'b0;
        item_ch.mode       = 1'b0;
        item_ch.process_id = '0;
        item_ch.event_id   = '0;
        item_ch.start_slot = '0;
        src_idle_pct       = 0;
        snk_idle_pct       = 0;
        hold_req           = 1'b0;
        pid_pool[0] = '0;
        pid_pool[1] = '1;
        for (int i = 2; i < 8; i++) pid_pool[i] = PID_W'($urandom);
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // directed: empty scans, process id zero, extremes of fields, repeats
        send_item(1'b1, '0, '0, '0);
        send_item(1'b1, '1, '1, '1);
        send_item(1'b0, '0, '0, '0);
        send_item(1'b0, '0, '0, '0);
        send_item(1'b1, '0, '0, '0);
        send_item(1'b0, '1, '1, '1);
        send_item(1'b0, '1, '1, '0);
        send_item(1'b0, '1, '0, '0);
        send_item(1'b0, 22'h155555, 9'h0AA, '0);
        send_item(1'b0, 22'h2AAAAA, 9'h155, '0);
        send_item(1'b1, '0, '0, '0);
        send_item(1'b1, '0, '1, '0);
        send_item(1'b1, '0, '1, 9'd1);
        send_item(1'b1, '0, 9'd200, 9'd1);
        send_item(1'b1, '0, 9'd2, 9'd2);
        send_item(1'b1, '0, '0, '1);
        send_item(1'b1, '0, '1, '1);
        drain();

        // random: mostly a small pool of processes and low events
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n < RANDOM_ITEMS / 3) begin
                src_idle_pct = 9;
                snk_idle_pct = 63;
            end else if (n < 2 * RANDOM_ITEMS / 3) begin
                src_idle_pct = 63;
                snk_idle_pct = 9;
            end else begin
                src_idle_pct = 0;
                snk_idle_pct = 0;
            end
            if (n == RANDOM_ITEMS / 3) hold_req = 1'b1;
            if (n == RANDOM_ITEMS / 2) drain();
            if ($urandom_range(99) < 70) begin
                pid = ($urandom_range(99) < 3) ? PID_W'($urandom)
                                               : pid_pool[$urandom_range(7)];
                send_item(1'b0, pid, pick_event(), SLOTI_W'($urandom));
            end else if ($urandom_range(99) < 85) begin
                send_item(1'b1, PID_W'($urandom), pick_event(), SLOTI_W'($urandom_range(31)));
            end else begin
                send_item(1'b1, PID_W'($urandom), EVID_W'($urandom), SLOTI_W'($urandom));
            end
        end
        drain();

        // fill every slot, then counts of new processes are dropped
        for (int i = 0; i < SLOT_COUNT_DEF + 8; i++)
            send_item(1'b0, PID_W'(22'h200000 + i), EVID_W'($urandom), '0);
        send_item(1'b0, 22'h3ABCDE, '1, '0);
        send_item(1'b1, '0, '0, '1);
        send_item(1'b1, '0, '1, '1);

        drain();
        repeat (100) @(negedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/core/ppect_pkg.sv
rtl/core/ppect_if.sv
rtl/core/ppect_ctrl.sv
rtl/core/ppect_dp.sv
rtl/core/per_process_event_count_table.sv
tb/per_process_event_count_table_chk.sv
tb/per_process_event_count_table_tb.sv
